### rtl/snell_pkg.sv
// ----------------------------------------------------------------------------
// snell_pkg: shared types and constants of the refraction block
// Number formats and the item types of the query and result channels.
// ----------------------------------------------------------------------------
package snell_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = COMP_WIDTH - 2;
  localparam int ETA_WIDTH  = 16;
  localparam int ETA_FRAC   = 13;
  localparam int ROOT_W     = FRAC_BITS + 1;
  localparam int RAD_W      = 2 * ROOT_W;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] wi_x;
    logic signed [COMP_WIDTH-1:0] wi_y;
    logic signed [COMP_WIDTH-1:0] wi_z;
    logic signed [COMP_WIDTH-1:0] n_x;
    logic signed [COMP_WIDTH-1:0] n_y;
    logic signed [COMP_WIDTH-1:0] n_z;
    logic        [ETA_WIDTH-1:0]  eta;
  } snell_query_t;

  typedef struct packed {
    logic signed [COMP_WIDTH-1:0] out_x;
    logic signed [COMP_WIDTH-1:0] out_y;
    logic signed [COMP_WIDTH-1:0] out_z;
    logic                         total_reflect;
  } snell_result_t;

endpackage

### rtl/snell_isqrt.sv
// ----------------------------------------------------------------------------
// snell_isqrt: pipelined integer square root
// Floor square root, one root bit per register stage, with a side word that
// travels alongside each item. Stages that hold no item close up under stall.
// ----------------------------------------------------------------------------
module snell_isqrt #(
  parameter int ROOT_BITS = 15,
  parameter int SIDE_W    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   src_valid,
  output logic                   src_stall,
  input  logic [2*ROOT_BITS-1:0] src_rad,
  input  logic [SIDE_W-1:0]      src_side,
  output logic                   dst_valid,
  input  logic                   dst_stall,
  output logic [ROOT_BITS-1:0]   dst_root,
  output logic [SIDE_W-1:0]      dst_side
);

  localparam int RW = 2 * ROOT_BITS + 1;

  logic [RW-1:0]        rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  logic [SIDE_W-1:0]    side_q [ROOT_BITS];
  logic                 vld    [ROOT_BITS];
  logic                 go     [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int BIT = ROOT_BITS - 1 - k;
    logic [RW-1:0]        rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [SIDE_W-1:0]    side_in;
    logic                 vld_in;
    logic [RW-1:0]        trial;
    logic                 fits;

    if (k == 0) begin : g_first
      assign rem_in  = {1'b0, src_rad};
      assign root_in = '0;
      assign side_in = src_side;
      assign vld_in  = src_valid;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld[k-1];
    end

    if (k == ROOT_BITS - 1) begin : g_last
      assign go[k] = !vld[k] || !dst_stall;
    end else begin : g_mid
      assign go[k] = !vld[k] || go[k+1];
    end

    assign trial = (RW'(root_in) << (BIT + 1)) | (RW'(1) << (2 * BIT));
    assign fits  = rem_in >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (go[k]) begin
        vld[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (go[k] && vld_in) begin
        rem_q[k]  <= fits ? rem_in - trial : rem_in;
        root_q[k] <= fits ? (root_in | (ROOT_BITS'(1) << BIT)) : root_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign src_stall = !go[0];
  assign dst_valid = vld[ROOT_BITS-1];
  assign dst_root  = root_q[ROOT_BITS-1];
  assign dst_side  = side_q[ROOT_BITS-1];

endmodule

### rtl/snell_refraction_vector.sv
// ----------------------------------------------------------------------------
// snell_refraction_vector: refracted direction by Snell's law
// Fixed-point refraction of a unit direction about a unit normal.
// ----------------------------------------------------------------------------
// The query channel carries one item per ray: incoming direction and normal
// in signed Q2.14 and the index ratio in unsigned Q3.13. The result channel
// returns one item per query, in order: the refracted direction, saturated
// to Q2.14, and a flag for total internal reflection with a zero vector.
// Both channels use valid and stall; an item moves at a clock edge with
// valid high and stall low.
// The block is a pipeline of 7 + 15 register stages, and a new query can be
// taken in every cycle while the pipeline is not stalled. The square root
// sets the depth, one root bit a stage.
// When the receiver stalls, the result register holds its item and empty
// stages behind it keep filling; queries are stalled only once the first
// stage holds an item that cannot move on.
// Synchronous reset empties every stage; no result is presented after it
// until a fresh query has gone through.
// ----------------------------------------------------------------------------
module snell_refraction_vector (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    query_valid,
  output logic                    query_stall,
  input  snell_pkg::snell_query_t query,
  output logic                    result_valid,
  input  logic                    result_stall,
  output snell_pkg::snell_result_t result
);

  import snell_pkg::*;

  localparam int W      = COMP_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int EW     = ETA_WIDTH + 1;
  localparam int PW     = 2 * W;
  localparam int SUM_W  = PW + 2;
  localparam int WP_W   = W + EW;
  localparam int WE_W   = WP_W - ETA_FRAC;
  localparam int CW     = F + 2;
  localparam int CP_W   = CW + EW;
  localparam int CE_W   = CP_W - ETA_FRAC;
  localparam int SQ_W   = 2 * CW;
  localparam int SIN_W  = F + 1;
  localparam int E2_W   = 2 * ETA_WIDTH;
  localparam int SP_W   = SIN_W + E2_W;
  localparam int SO_W   = SP_W - 2 * ETA_FRAC;
  localparam int CO_W   = CE_W + 1;
  localparam int MP_W   = CO_W + W;
  localparam int MT_W   = MP_W - F;
  localparam int TW     = MT_W + 1;
  localparam int SIDE_W = 1 + CE_W + 3 * WE_W + 3 * W;

  localparam longint ONE_L = longint'(1) << F;
  localparam longint MAX_L = (longint'(1) << (W - 1)) - 1;

  localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(ONE_L);
  localparam logic signed [CW-1:0]    ONE_C   = CW'(ONE_L);
  localparam logic signed [TW-1:0]    MAX_T   = TW'(MAX_L);
  localparam logic signed [TW-1:0]    MIN_T   = TW'(-MAX_L - 1);

  // Stage 0: products of the dot product and the squared ratio.
  logic                    s0_v;
  logic signed [W-1:0]     s0_wi [3];
  logic signed [W-1:0]     s0_n  [3];
  logic signed [PW-1:0]    s0_p  [3];
  logic [ETA_WIDTH-1:0]    s0_eta;
  logic [E2_W-1:0]         s0_e2;

  // Stage 1: clamped cosine and the scaled incoming direction.
  logic                    s1_v;
  logic signed [CW-1:0]    s1_c;
  logic signed [W-1:0]     s1_n    [3];
  logic signed [WE_W-1:0]  s1_weta [3];
  logic [ETA_WIDTH-1:0]    s1_eta;
  logic [E2_W-1:0]         s1_e2;

  // Stage 2: squared cosine and the cosine times the ratio.
  logic                    s2_v;
  logic signed [SQ_W-1:0]  s2_csq;
  logic signed [CE_W-1:0]  s2_ceta;
  logic signed [W-1:0]     s2_n    [3];
  logic signed [WE_W-1:0]  s2_weta [3];
  logic [E2_W-1:0]         s2_e2;

  // Stage 3: squared sine of the transmitted ray.
  logic                    s3_v;
  logic [SO_W-1:0]         s3_so2;
  logic signed [CE_W-1:0]  s3_ceta;
  logic signed [W-1:0]     s3_n    [3];
  logic signed [WE_W-1:0]  s3_weta [3];

  // Stage 4: reflection test and the radicand.
  logic                    s4_v;
  logic                    s4_tir;
  logic [RAD_W-1:0]        s4_rad;
  logic signed [CE_W-1:0]  s4_ceta;
  logic signed [W-1:0]     s4_n    [3];
  logic signed [WE_W-1:0]  s4_weta [3];

  // Square root outputs.
  logic                    sq_src_stall;
  logic                    sq_dst_valid;
  logic                    sq_dst_stall;
  logic [ROOT_W-1:0]       sq_root;
  logic [SIDE_W-1:0]       sq_side_in;
  logic [SIDE_W-1:0]       sq_side_out;
  logic                    sq_tir;
  logic signed [CE_W-1:0]  sq_ceta;
  logic signed [W-1:0]     sq_n    [3];
  logic signed [WE_W-1:0]  sq_weta [3];

  // Stage M: normal term.
  logic                    sm_v;
  logic                    sm_tir;
  logic signed [MT_W-1:0]  sm_mt   [3];
  logic signed [WE_W-1:0]  sm_weta [3];

  // Output stage.
  logic                    so_v;
  logic                    so_tir;
  logic signed [W-1:0]     so_out [3];

  logic go0, go1, go2, go3, go4, go_m, go_o;

  assign go_o         = !so_v || !result_stall;
  assign go_m         = !sm_v || go_o;
  assign sq_dst_stall = !go_m;
  assign go4          = !s4_v || !sq_src_stall;
  assign go3          = !s3_v || go4;
  assign go2          = !s2_v || go3;
  assign go1          = !s1_v || go2;
  assign go0          = !s0_v || go1;
  assign query_stall  = !go0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      sm_v <= 1'b0;
      so_v <= 1'b0;
    end else begin
      if (go0)  s0_v <= query_valid;
      if (go1)  s1_v <= s0_v;
      if (go2)  s2_v <= s1_v;
      if (go3)  s3_v <= s2_v;
      if (go4)  s4_v <= s3_v;
      if (go_m) sm_v <= sq_dst_valid;
      if (go_o) so_v <= sm_v;
    end
  end

  // Stage 0
  always_ff @(posedge clk) begin
    if (go0 && query_valid) begin
      s0_wi[0] <= query.wi_x;
      s0_wi[1] <= query.wi_y;
      s0_wi[2] <= query.wi_z;
      s0_n[0]  <= query.n_x;
      s0_n[1]  <= query.n_y;
      s0_n[2]  <= query.n_z;
      s0_p[0]  <= PW'(query.wi_x) * PW'(query.n_x);
      s0_p[1]  <= PW'(query.wi_y) * PW'(query.n_y);
      s0_p[2]  <= PW'(query.wi_z) * PW'(query.n_z);
      s0_eta   <= query.eta;
      s0_e2    <= E2_W'(query.eta) * E2_W'(query.eta);
    end
  end

  // Stage 1
  logic signed [SUM_W-1:0] dot_sum;
  logic signed [SUM_W-1:0] dot_c;
  logic signed [CW-1:0]    c_clamp;
  logic signed [WP_W-1:0]  wprod [3];

  assign dot_sum = SUM_W'(s0_p[0]) + SUM_W'(s0_p[1]) + SUM_W'(s0_p[2]);
  assign dot_c   = dot_sum >>> F;

  always_comb begin
    priority if (dot_c > ONE_SUM) begin
      c_clamp = ONE_C;
    end else if (dot_c < -ONE_SUM) begin
      c_clamp = -ONE_C;
    end else begin
      c_clamp = CW'(dot_c);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_weta
    assign wprod[k] = -(WP_W'(s0_wi[k]) * WP_W'($signed({1'b0, s0_eta})));
  end

  always_ff @(posedge clk) begin
    if (go1 && s0_v) begin
      s1_c   <= c_clamp;
      s1_eta <= s0_eta;
      s1_e2  <= s0_e2;
      for (int k = 0; k < 3; k++) begin
        s1_n[k]    <= s0_n[k];
        s1_weta[k] <= WE_W'(wprod[k] >>> ETA_FRAC);
      end
    end
  end

  // Stage 2
  logic signed [CP_W-1:0] cprod;

  assign cprod = CP_W'(s1_c) * CP_W'($signed({1'b0, s1_eta}));

  always_ff @(posedge clk) begin
    if (go2 && s1_v) begin
      s2_csq  <= SQ_W'(s1_c) * SQ_W'(s1_c);
      s2_ceta <= CE_W'(cprod >>> ETA_FRAC);
      s2_e2   <= s1_e2;
      s2_n    <= s1_n;
      s2_weta <= s1_weta;
    end
  end

  // Stage 3
  logic [SIN_W-1:0] sin2i;
  logic [SP_W-1:0]  sprod;

  assign sin2i = SIN_W'(ONE_L) - s2_csq[2*F:F];
  assign sprod = SP_W'(sin2i) * SP_W'(s2_e2);

  always_ff @(posedge clk) begin
    if (go3 && s2_v) begin
      s3_so2  <= SO_W'(sprod >> (2 * ETA_FRAC));
      s3_ceta <= s2_ceta;
      s3_n    <= s2_n;
      s3_weta <= s2_weta;
    end
  end

  // Stage 4
  logic             tir;
  logic [SIN_W-1:0] cos2o;

  assign tir   = s3_so2 >= SO_W'(ONE_L);
  assign cos2o = SIN_W'(SO_W'(ONE_L) - s3_so2);

  always_ff @(posedge clk) begin
    if (go4 && s3_v) begin
      s4_tir  <= tir;
      s4_rad  <= tir ? '0 : (RAD_W'(cos2o) << F);
      s4_ceta <= s3_ceta;
      s4_n    <= s3_n;
      s4_weta <= s3_weta;
    end
  end

  assign sq_side_in = {s4_tir, s4_ceta, s4_weta[0], s4_weta[1], s4_weta[2],
                       s4_n[0], s4_n[1], s4_n[2]};

  snell_isqrt #(
    .ROOT_BITS (ROOT_W),
    .SIDE_W    (SIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .src_valid (s4_v),
    .src_stall (sq_src_stall),
    .src_rad   (s4_rad),
    .src_side  (sq_side_in),
    .dst_valid (sq_dst_valid),
    .dst_stall (sq_dst_stall),
    .dst_root  (sq_root),
    .dst_side  (sq_side_out)
  );

  assign {sq_tir, sq_ceta, sq_weta[0], sq_weta[1], sq_weta[2],
          sq_n[0], sq_n[1], sq_n[2]} = sq_side_out;

  // Stage M
  logic signed [CO_W-1:0] coef;
  logic signed [MP_W-1:0] mprod [3];

  assign coef = CO_W'(sq_ceta) - $signed(CO_W'(sq_root));

  for (genvar k = 0; k < 3; k++) begin : g_norm
    assign mprod[k] = MP_W'(coef) * MP_W'(sq_n[k]);
  end

  always_ff @(posedge clk) begin
    if (go_m && sq_dst_valid) begin
      sm_tir  <= sq_tir;
      sm_weta <= sq_weta;
      for (int k = 0; k < 3; k++) begin
        sm_mt[k] <= MT_W'(mprod[k] >>> F);
      end
    end
  end

  // Output stage
  logic signed [TW-1:0] tsum [3];
  logic signed [W-1:0]  tsat [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsum[k] = TW'(sm_weta[k]) + TW'(sm_mt[k]);
      priority if (sm_tir) begin
        tsat[k] = '0;
      end else if (tsum[k] > MAX_T) begin
        tsat[k] = W'(MAX_T);
      end else if (tsum[k] < MIN_T) begin
        tsat[k] = W'(MIN_T);
      end else begin
        tsat[k] = W'(tsum[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_o && sm_v) begin
      so_tir <= sm_tir;
      so_out <= tsat;
    end
  end

  assign result_valid         = so_v;
  assign result.out_x         = so_out[0];
  assign result.out_y         = so_out[1];
  assign result.out_z         = so_out[2];
  assign result.total_reflect = so_tir;

  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.total_reflect |->
      result.out_x == '0 && result.out_y == '0 && result.out_z == '0)
    else $error("reflected item carries a non-zero vector");

  a_root_bound: assert property (@(posedge clk) disable iff (rst)
    sq_dst_valid |-> sq_root <= ROOT_W'(ONE_L))
    else $error("square root exceeds one");

  a_stage4_hold: assert property (@(posedge clk) disable iff (rst)
    s4_v && sq_src_stall |=> s4_v && $stable(s4_rad) && $stable(s4_tir))
    else $error("stalled radicand was lost or changed");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    query_stall |-> s0_v && s1_v)
    else $error("query stalled with room in the first stages");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result presented straight after reset");

endmodule
